// ===== rtl/core/ctlf_pkg.sv =====
// Package: word types and controller states for the closed tour length block.
`timescale 1ns / 1ps
package ctlf_pkg;

    // coordinate width carried by the city word
    localparam int COORD_BITS = 16;

    typedef struct packed {
        logic [COORD_BITS-1:0] city_x;
        logic [COORD_BITS-1:0] city_y;
        logic                  last_city;
    } t_city_word;

    typedef struct packed {
        logic [31:0] tour_length;
        logic [31:0] tour_fitness;
    } t_result_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } t_state;

    localparam logic [31:0] SCALE_RESET = 32'd10000;
    localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;

endpackage

// ===== rtl/core/closed_tour_length_and_fitness.sv =====
// Top level: closed tour length and fitness over a stream of city words.
`timescale 1ns / 1ps
// The first city word of a tour is stored as the start city. Every later city
// word is accepted, its deltas are squared serially, a bit-pair square root of
// 32 + FRAC_BITS digits is taken (one root bit per cycle) and the root is added
// to the running length. A
// last city runs two legs, then a restoring divide of 32 + 2*FRAC_BITS
// quotient bits, one per cycle, and then loads the result register.
// One city is in work at a time; the result word sits in an output register
// and the block takes the next city word once the result has left.
module closed_tour_length_and_fitness #(
    parameter int FRAC_BITS  = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  ctlf_pkg::t_city_word       i_city,
    output logic                       o_valid,
    input  logic                       i_stall,
    output ctlf_pkg::t_result_word     o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [31:0]                i_cfg_data
);
    localparam int COORD_BITS = ctlf_pkg::COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int RT_N   = 32 + FRAC_BITS;          // root digits
    localparam int RAD_W  = 2 * RT_N;                // padded radicand
    localparam int REM_W  = RT_N + 2;
    localparam int NUM_W  = 32 + 2 * FRAC_BITS;
    localparam int DIV_N  = NUM_W;
    localparam int ADD_W  = RT_N + 1;
    localparam int CW     = 7;

    ctlf_pkg::t_state r_state, n_state;
    logic [COORD_BITS-1:0] r_fx, r_fy, r_px, r_py, r_cx, r_cy;
    logic r_have, r_last, r_close;
    logic [31:0] r_scale, r_sum;
    logic [COORD_BITS-1:0] r_mx, r_my;     // multiplier bits shifted out
    logic [COORD_BITS-1:0] r_ax, r_ay;     // multiplicands
    logic [SQ_W-1:0] r_sq;
    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [RT_N-1:0] r_root;
    logic [NUM_W-1:0] r_num;
    logic [32:0] r_drem;
    logic [NUM_W-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    ctlf_pkg::t_result_word r_out;
    logic r_ovalid;

    wire acc_in = i_valid && !o_stall;
    assign o_stall = (r_state != ctlf_pkg::ST_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_result = r_out;
    assign o_cfg_ready = 1'b1;

    // Leg endpoints: current city against previous, or against first on close
    logic [COORD_BITS-1:0] w_bx, w_by, w_dx, w_dy;
    always_comb begin
        w_bx = r_close ? r_fx : r_px;
        w_by = r_close ? r_fy : r_py;
        w_dx = (r_cx > w_bx) ? r_cx - w_bx : w_bx - r_cx;
        w_dy = (r_cy > w_by) ? r_cy - w_by : w_by - r_cy;
    end

    // Square step: shift the partial sum, add both multiplicands on set bits
    logic [SQ_W-1:0] w_sq_next;
    always_comb begin
        w_sq_next = {r_sq[SQ_W-2:0], 1'b0}
                  + (r_mx[COORD_BITS-1] ? SQ_W'(r_ax) : '0)
                  + (r_my[COORD_BITS-1] ? SQ_W'(r_ay) : '0);
    end

    // Root step: bring in next bit pair, trial subtract
    logic [REM_W-1:0] w_rem_sh, w_trial;
    always_comb begin
        w_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        w_trial  = {r_root, 2'b01};
    end

    // Divide step
    logic [33:0] w_dsh;
    always_comb w_dsh = {r_drem, r_num[NUM_W-1]};

    logic [ADD_W-1:0] w_add;
    always_comb w_add = ADD_W'(r_sum) + ADD_W'(r_root);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ctlf_pkg::ST_IDLE: begin
                if (acc_in) begin
                    if (!r_have) n_state = i_city.last_city ? ctlf_pkg::ST_DIV
                                                           : ctlf_pkg::ST_IDLE;
                    else n_state = ctlf_pkg::ST_SQUARE;
                end
            end
            ctlf_pkg::ST_SQUARE: if (r_cnt == CW'(COORD_BITS)) n_state = ctlf_pkg::ST_ROOT;
            ctlf_pkg::ST_ROOT:   if (r_cnt == CW'(RT_N - 1)) n_state = ctlf_pkg::ST_ADD;
            ctlf_pkg::ST_ADD: begin
                if (r_last && !r_close) n_state = ctlf_pkg::ST_SQUARE;
                else if (r_last) n_state = ctlf_pkg::ST_DIV;
                else n_state = ctlf_pkg::ST_IDLE;
            end
            ctlf_pkg::ST_DIV:    if (r_cnt == CW'(DIV_N - 1)) n_state = ctlf_pkg::ST_OUT;
            ctlf_pkg::ST_OUT:    n_state = ctlf_pkg::ST_IDLE;
            default:             n_state = ctlf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ctlf_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_sum    <= '0;
            r_scale  <= ctlf_pkg::SCALE_RESET;
            r_ovalid <= 1'b0;
            r_close  <= 1'b0;
            r_last   <= 1'b0;
            r_cnt    <= '0;
            r_fx <= '0; r_fy <= '0; r_px <= '0; r_py <= '0;
        end else begin
            if (i_cfg_valid) r_scale <= i_cfg_data;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                ctlf_pkg::ST_IDLE: begin
                    r_cnt <= '0;
                    r_close <= 1'b0;
                    if (acc_in) begin
                        r_cx <= i_city.city_x[COORD_BITS-1:0];
                        r_cy <= i_city.city_y[COORD_BITS-1:0];
                        r_last <= i_city.last_city;
                        if (!r_have) begin
                            r_fx <= i_city.city_x[COORD_BITS-1:0];
                            r_fy <= i_city.city_y[COORD_BITS-1:0];
                            r_px <= i_city.city_x[COORD_BITS-1:0];
                            r_py <= i_city.city_y[COORD_BITS-1:0];
                            r_sum <= '0;
                            r_have <= !i_city.last_city;
                            r_num <= {r_scale, {(2*FRAC_BITS){1'b0}}};
                            r_drem <= '0;
                        end
                    end
                end
                ctlf_pkg::ST_SQUARE: begin
                    // the first step loads operands; then one shift-add per cycle
                    if (r_cnt == '0) begin
                        r_ax <= w_dx; r_mx <= w_dx;
                        r_ay <= w_dy; r_my <= w_dy;
                        r_sq <= '0;
                    end else begin
                        r_sq <= w_sq_next;
                        r_mx <= {r_mx[COORD_BITS-2:0], 1'b0};
                        r_my <= {r_my[COORD_BITS-2:0], 1'b0};
                    end
                    // last step: load radicand padded with fractional zero pairs
                    if (r_cnt == CW'(COORD_BITS)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_root <= '0;
                        r_rad <= RAD_W'(w_sq_next) << (2 * FRAC_BITS);
                    end else r_cnt <= r_cnt + 1'b1;
                end
                ctlf_pkg::ST_ROOT: begin
                    if (w_rem_sh >= w_trial) begin
                        r_rem <= w_rem_sh - w_trial;
                        r_root <= {r_root[RT_N-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_root <= {r_root[RT_N-2:0], 1'b0};
                    end
                    r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                    r_cnt <= r_cnt + 1'b1;
                end
                ctlf_pkg::ST_ADD: begin
                    r_sum <= (|w_add[ADD_W-1:32]) ? ctlf_pkg::SAT32 : w_add[31:0];
                    r_cnt <= '0;
                    r_close <= 1'b1;
                    r_num <= {r_scale, {(2*FRAC_BITS){1'b0}}};
                    r_drem <= '0;
                    // current city becomes the previous one after its leg
                    if (!r_close) begin
                        r_px <= r_cx;
                        r_py <= r_cy;
                    end
                    if (r_last && r_close) r_have <= 1'b0;
                end
                ctlf_pkg::ST_DIV: begin
                    if (w_dsh >= {2'b00, r_sum}) begin
                        r_drem <= 33'(w_dsh - {2'b00, r_sum});
                        r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                    end else begin
                        r_drem <= w_dsh[32:0];
                        r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                    end
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                end
                ctlf_pkg::ST_OUT: begin
                    r_out.tour_length <= r_sum;
                    if (r_sum == '0 || (|(r_quo >> 32)))
                        r_out.tour_fitness <= ctlf_pkg::SAT32;
                    else r_out.tour_fitness <= r_quo[31:0];
                    r_ovalid <= 1'b1;
                    r_sum <= '0;
                end
                default: ;
            endcase
        end
    end

    // Assertions
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ctlf_pkg::ST_IDLE) |-> o_stall)
        else $error("accepted city while busy");
    a_out_zero_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.tour_length == 32'd0) |-> o_result.tour_fitness == 32'hFFFF_FFFF)
        else $error("zero length without saturated fitness");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_result))
        else $error("result word changed under stall");
endmodule
